>>> rtl/apga_pkg.sv
// Shared constants, codes, types and index helpers for the adjacent pair grant arbiter.
package apga_pkg;

  localparam int SEATS  = 5;
  localparam int SEAT_W = 3;
  localparam int RES_W  = $clog2(SEATS);
  localparam int QCNT_W = $clog2(SEATS + 1);

  localparam logic [1:0] CMD_EAT     = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_END     = 2'd2;
  // Command code with no meaning to the arbiter; it is always rejected.
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  localparam logic [1:0] REPLY_OK  = 2'd0;
  localparam logic [1:0] REPLY_NO  = 2'd1;
  localparam logic [1:0] REPLY_ERR = 2'd2;

  typedef enum logic [1:0] {
    KIND_ERR,
    KIND_EAT,
    KIND_REL,
    KIND_END
  } kind_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic drop;
    logic head;
    logic fin_chk;
    logic advance;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  drop_more;
    logic  res_any;
    logic  res_last;
  } dp_sts_t;

  // Resource index (k + off) mod SEATS, with k in 1..SEATS and off at most 2.
  function automatic logic [RES_W-1:0] res_idx(input logic [SEAT_W-1:0] k,
                                               input logic [1:0] off);
    logic [SEAT_W:0] s;
    s = {1'b0, k} + (SEAT_W + 1)'(off);
    if (s >= (SEAT_W + 1)'(SEATS)) begin
      s = s - (SEAT_W + 1)'(SEATS);
    end
    return RES_W'(s);
  endfunction

  // Zero-based slot of seat k, with k in 1..SEATS.
  function automatic logic [RES_W-1:0] seat_slot(input logic [SEAT_W-1:0] k);
    logic [SEAT_W-1:0] d;
    d = k - SEAT_W'(1);
    return RES_W'(d);
  endfunction

endpackage

>>> rtl/apga_dpath.sv
// Datapath of the arbiter: resource, queue, grant and result registers.
module apga_dpath (
  input  logic                      clk,
  input  logic                      rst,
  input  apga_pkg::dp_cmd_t         cmd_in,
  output apga_pkg::dp_sts_t         sts,
  input  logic [1:0]                cmd,
  input  logic [apga_pkg::SEAT_W-1:0] seat,
  output logic [1:0]                reply,
  output logic [apga_pkg::SEAT_W-1:0] reply_seat,
  output logic                      last
);
  import apga_pkg::*;

  logic [1:0]        cmd_r;
  logic [SEAT_W-1:0] seat_r;
  logic [SEATS-1:0]  resource_free;
  logic [SEATS-1:0]  pending_grant;
  logic [SEAT_W-1:0] wait_queue [SEATS];
  logic [QCNT_W-1:0] queue_count;
  logic [QCNT_W-1:0] finished_count;
  logic [1:0]        res_reply [2];
  logic [1:0]        res_n;
  logic              out_idx;

  kind_t             kind;
  logic [RES_W-1:0]  ra, rb, rlo, rhi, ha, hb;
  logic [SEAT_W-1:0] head_seat;
  logic              dup, head_take, fin_hit;

  always_comb begin
    if (cmd_r == CMD_UNKNOWN || seat_r == '0 || seat_r > SEAT_W'(SEATS)) begin
      kind = KIND_ERR;
    end else if (cmd_r == CMD_EAT) begin
      kind = KIND_EAT;
    end else if (cmd_r == CMD_RELEASE) begin
      kind = KIND_REL;
    end else begin
      kind = KIND_END;
    end
  end

  assign ra        = res_idx(seat_r, 2'd0);
  assign rb        = res_idx(seat_r, 2'd1);
  assign rhi       = res_idx(seat_r, 2'd2);
  assign rlo       = seat_slot(seat_r);
  assign head_seat = wait_queue[0];
  assign ha        = res_idx(head_seat, 2'd0);
  assign hb        = res_idx(head_seat, 2'd1);

  always_comb begin
    dup = 1'b0;
    for (int i = 0; i < SEATS; i++) begin
      if (QCNT_W'(i) < queue_count && wait_queue[i] == seat_r) begin
        dup = 1'b1;
      end
    end
  end

  assign head_take = (queue_count != '0) && resource_free[ha] && resource_free[hb] &&
                     (finished_count < QCNT_W'(SEATS - 1));
  assign fin_hit   = pending_grant[seat_slot(seat_r)] ||
                     (finished_count == QCNT_W'(SEATS - 1));

  assign sts.kind      = kind;
  assign sts.drop_more = (queue_count != '0) && (head_seat == '0);
  assign sts.res_any   = (res_n != 2'd0);
  assign sts.res_last  = last;

  assign reply      = res_reply[out_idx];
  assign reply_seat = seat_r;
  assign last       = (res_n == 2'd2) ? out_idx : 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      resource_free  <= '1;
      pending_grant  <= '0;
      queue_count    <= '0;
      finished_count <= '0;
      res_n          <= '0;
      out_idx        <= 1'b0;
      for (int i = 0; i < SEATS; i++) begin
        wait_queue[i] <= '0;
      end
    end else begin
      if (cmd_in.load) begin
        cmd_r   <= cmd;
        seat_r  <= seat;
        res_n   <= '0;
        out_idx <= 1'b0;
      end
      if (cmd_in.exec) begin
        case (kind)
          KIND_ERR: begin
            res_reply[0] <= REPLY_ERR;
            res_n        <= 2'd1;
          end
          KIND_END: begin
            for (int i = 0; i < SEATS; i++) begin
              if (QCNT_W'(i) < queue_count && wait_queue[i] == seat_r) begin
                wait_queue[i] <= '0;
              end
            end
            if (!resource_free[ra] && !resource_free[rb] &&
                (resource_free[rlo] || resource_free[rhi])) begin
              resource_free[ra] <= 1'b1;
              resource_free[rb] <= 1'b1;
            end
            if (finished_count < QCNT_W'(SEATS)) begin
              finished_count <= finished_count + QCNT_W'(1);
            end
          end
          KIND_EAT: begin
            if (!pending_grant[seat_slot(seat_r)]) begin
              if (resource_free[ra] && resource_free[rb]) begin
                resource_free[ra] <= 1'b0;
                resource_free[rb] <= 1'b0;
                res_reply[0]      <= REPLY_OK;
              end else begin
                if (!dup && queue_count < QCNT_W'(SEATS)) begin
                  for (int i = 0; i < SEATS; i++) begin
                    if (QCNT_W'(i) == queue_count) begin
                      wait_queue[i] <= seat_r;
                    end
                  end
                  queue_count <= queue_count + QCNT_W'(1);
                end
                res_reply[0] <= REPLY_NO;
              end
              res_n <= 2'd1;
            end
          end
          KIND_REL: begin
            resource_free[ra] <= 1'b1;
            resource_free[rb] <= 1'b1;
          end
          default: begin
          end
        endcase
      end
      if (cmd_in.drop || (cmd_in.head && head_take)) begin
        for (int i = 0; i < SEATS - 1; i++) begin
          wait_queue[i] <= wait_queue[i + 1];
        end
        wait_queue[SEATS - 1] <= '0;
        queue_count           <= queue_count - QCNT_W'(1);
      end
      if (cmd_in.head && head_take) begin
        resource_free[ha]                  <= 1'b0;
        resource_free[hb]                  <= 1'b0;
        pending_grant[seat_slot(head_seat)] <= 1'b1;
      end
      if (cmd_in.fin_chk && fin_hit) begin
        pending_grant[seat_slot(seat_r)] <= 1'b0;
        res_reply[res_n[0]]              <= REPLY_OK;
        res_n                            <= res_n + 2'd1;
      end
      if (cmd_in.advance) begin
        out_idx <= 1'b1;
      end
    end
  end

endmodule

>>> rtl/apga_ctrl.sv
// Controller state machine that sequences each transfer through the datapath.
module apga_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output apga_pkg::dp_cmd_t cmd_out,
  input  apga_pkg::dp_sts_t sts
);
  import apga_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_DROP  = 6'b000100,
    S_HEAD  = 6'b001000,
    S_FINAL = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state, state_next;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT) && sts.res_any;

  always_comb begin
    state_next      = state;
    cmd_out         = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd_out.load = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_out.exec = 1'b1;
        case (sts.kind)
          KIND_ERR: state_next = S_OUT;
          KIND_END: state_next = S_IDLE;
          KIND_EAT: state_next = S_FINAL;
          KIND_REL: state_next = S_DROP;
          default:  state_next = S_IDLE;
        endcase
      end
      S_DROP: begin
        if (sts.drop_more) begin
          cmd_out.drop = 1'b1;
        end else begin
          state_next = S_HEAD;
        end
      end
      S_HEAD: begin
        cmd_out.head = 1'b1;
        state_next   = S_FINAL;
      end
      S_FINAL: begin
        cmd_out.fin_chk = 1'b1;
        state_next      = S_OUT;
      end
      S_OUT: begin
        if (!sts.res_any) begin
          state_next = S_IDLE;
        end else if (!out_stall) begin
          if (sts.res_last) begin
            state_next = S_IDLE;
          end else begin
            cmd_out.advance = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/adjacent_pair_grant_arbiter_core.sv
// Top level of the adjacent pair grant arbiter: controller plus datapath.
//
//   Channel   Handshake              Fields
//   input     in_valid / in_stall    cmd[1:0], seat[2:0]
//   output    out_valid / out_stall  reply[1:0], reply_seat[2:0], last
//
// One input transfer is taken at a time. END executes and goes back to idle, a bad
// request executes and gives its error reply, and EAT executes, checks the grant
// and gives one or two replies. RELEASE runs execute, a queue head check with one
// drop per finished marker (up to SEATS), head try, grant check and an output step,
// even when no reply follows. An output stall holds the output step, and in_stall
// stays high until the last result of the transfer has gone out. Reset is
// synchronous and clears all but the captured command, seat and reply registers.
module adjacent_pair_grant_arbiter_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  cmd,
  input  logic [apga_pkg::SEAT_W-1:0] seat,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  reply,
  output logic [apga_pkg::SEAT_W-1:0] reply_seat,
  output logic                        last
);
  import apga_pkg::*;

  // Commands flow from the controller to the datapath; status flows back.
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  apga_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd_out   (dp_cmd),
    .sts       (dp_sts)
  );

  apga_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd_in     (dp_cmd),
    .sts        (dp_sts),
    .cmd        (cmd),
    .seat       (seat),
    .reply      (reply),
    .reply_seat (reply_seat),
    .last       (last)
  );

  // The arbiter never takes a new request while a result is being offered.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted while a result is pending");

  // An accepted request always closes the input side on the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not held off after a transfer");

  // An error reply is always the only and final reply of its request.
  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && reply == REPLY_ERR) |-> last)
    else $error("error reply not marked last");

  // After the final result is taken, no further result follows at once.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last) |=> !out_valid)
    else $error("result offered after the last one");

endmodule
